@@ src/cta_pkg.sv @@
// ---------------------------------------------------------------------------
// cta_pkg
// Shared types and constants for the cascaded temperature averager.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package cta_pkg;

    localparam int TEMP_W    = 16;
    localparam int TIME_W    = 32;
    localparam int DIV_W     = 33;
    localparam int ENTRY_W   = TEMP_W + 1;

    localparam int WIN_SECONDS   = 60;
    localparam int WIN_MINUTES   = 60;
    localparam int WIN_HOURS     = 24;
    localparam int SECS_PER_MIN  = 60;
    localparam int SECS_PER_HOUR = 3600;
    localparam int SECS_PER_DAY  = 86400;

    localparam int CNT_W = $clog2(WIN_SECONDS + 1);
    localparam int SUM_W = TEMP_W + CNT_W;

    // periods split into a power of two and an odd factor
    localparam int MIN_SHIFT  = 2;   // 60 = 4 * 15
    localparam int HOUR_SHIFT = 4;   // 3600 = 16 * 225
    localparam int DAY_SHIFT  = 7;   // 86400 = 128 * 675

    // inverse of an odd value mod 2^32, newton steps double the good bits
    function automatic logic [31:0] f_odd_inverse(input logic [31:0] a);
        logic [31:0] x;
        x = a;
        for (int i = 0; i < 5; i++) begin
            x = x * (32'd2 - a * x);
        end
        return x;
    endfunction

    // x is a multiple of the odd factor when x * inverse mod 2^32 <= limit
    localparam logic [31:0] MIN_INV  = f_odd_inverse(32'd15);
    localparam logic [31:0] MIN_LIM  = 32'hffff_ffff / 32'd15;
    localparam logic [31:0] HOUR_INV = f_odd_inverse(32'd225);
    localparam logic [31:0] HOUR_LIM = 32'hffff_ffff / 32'd225;
    localparam logic [31:0] DAY_INV  = f_odd_inverse(32'd675);
    localparam logic [31:0] DAY_LIM  = 32'hffff_ffff / 32'd675;

    // register byte addresses
    localparam logic [2:0] REG_LOG_PERIOD = 3'd0;

    typedef enum logic [1:0] {
        LV_SEC  = 2'd0,
        LV_MIN  = 2'd1,
        LV_HOUR = 2'd2
    } t_level;

    typedef struct packed {
        logic                done;
        logic [DIV_W-1:0]    quot;
        logic [TIME_W-1:0]   rem;
    } t_div_status;

endpackage

@@ src/cta_if.sv @@
// ---------------------------------------------------------------------------
// cta_if
// Handshake channels for sample items and result items.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

interface cta_in_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] temperature;
    logic [31:0]        time_seconds;

    modport source (output valid, temperature, time_seconds, input ready);
    modport sink   (input valid, temperature, time_seconds, output ready);
endinterface

interface cta_out_if;
    logic               valid;
    logic               ready;
    logic               log_now;
    logic               minute_done;
    logic signed [15:0] minute_average;
    logic               hour_done;
    logic signed [15:0] hour_average;
    logic               day_done;
    logic signed [15:0] day_average;

    modport source (output valid, log_now, minute_done, minute_average, hour_done,
                    hour_average, day_done, day_average, input ready);
    modport sink   (input valid, log_now, minute_done, minute_average, hour_done,
                    hour_average, day_done, day_average, output ready);
endinterface

@@ src/cta_ram.sv @@
// ---------------------------------------------------------------------------
// cta_ram
// Generic single write port, single read port RAM with registered read.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module cta_ram #(
    parameter int WIDTH = 17,
    parameter int DEPTH = 128
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ src/cta_div.sv @@
// ---------------------------------------------------------------------------
// cta_div
// Unsigned restoring divider, one quotient bit per cycle.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module cta_div
    import cta_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [DIV_W-1:0]  i_dividend,
    input  logic [TIME_W-1:0] i_divisor,
    output t_div_status       o_status
);

    logic [DIV_W-1:0]         r_rem;
    logic [DIV_W-1:0]         r_quot;
    logic [TIME_W-1:0]        r_divisor;
    logic [$clog2(DIV_W):0]   r_cnt;
    logic                     r_busy;
    logic                     r_done;
    logic [DIV_W-1:0]         trial;
    logic                     ge;

    assign trial = {r_rem[DIV_W-2:0], r_quot[DIV_W-1]};
    assign ge    = (trial >= {1'b0, r_divisor});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy    <= 1'b1;
                r_cnt     <= ($clog2(DIV_W)+1)'(DIV_W);
                r_rem     <= '0;
                r_quot    <= i_dividend;
                r_divisor <= i_divisor;
            end else if (r_busy) begin
                r_rem  <= ge ? (trial - {1'b0, r_divisor}) : trial;
                r_quot <= {r_quot[DIV_W-2:0], ge};
                r_cnt  <= r_cnt - 1'b1;
                if (r_cnt == ($clog2(DIV_W)+1)'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_status.done = r_done;
    assign o_status.quot = r_quot;
    assign o_status.rem  = r_rem[TIME_W-1:0];

endmodule

@@ src/cascaded_temperature_averager.sv @@
// a plain sample goes from the taking edge through S_M60 and S_LOG to the result in S_OUT; with
// a log period set, S_LOGW adds one divider pass; a minute or an hour average adds a walk
// reading one ring entry a cycle, then a divider pass, and so does a day average
// throughput: one item at a time; the next item is taken the cycle after the result is registered
// reset: synchronous, active low; then a clearing pass that writes zeros to every address
// empties all three rings before the first item is taken
`timescale 1ns / 1ps

// ---------------------------------------------------------------------------
// cascaded_temperature_averager
// Per-second sample ring cascaded into minute and hour rings with averaging.
// ---------------------------------------------------------------------------
module cascaded_temperature_averager
    import cta_pkg::*;
#(
    parameter int SECOND_DEPTH = 128,
    parameter int MINUTE_DEPTH = 128,
    parameter int HOUR_DEPTH   = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    cta_in_if.sink      i_in,
    cta_out_if.source   o_out,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int SAW  = $clog2(SECOND_DEPTH);
    localparam int MAW  = $clog2(MINUTE_DEPTH);
    localparam int HAW  = $clog2(HOUR_DEPTH);
    localparam int MAXD = (SECOND_DEPTH > MINUTE_DEPTH)
                        ? ((SECOND_DEPTH > HOUR_DEPTH) ? SECOND_DEPTH : HOUR_DEPTH)
                        : ((MINUTE_DEPTH > HOUR_DEPTH) ? MINUTE_DEPTH : HOUR_DEPTH);
    localparam int PW   = $clog2(MAXD);
    localparam int CLW  = $clog2(MAXD);

    typedef enum logic [10:0] {
        S_CLEAR  = 11'b000_0000_0001,
        S_IDLE   = 11'b000_0000_0010,
        S_M60    = 11'b000_0000_0100,
        S_WALK   = 11'b000_0000_1000,
        S_AVG    = 11'b000_0001_0000,
        S_STORE  = 11'b000_0010_0000,
        S_M3600  = 11'b000_0100_0000,
        S_M86400 = 11'b000_1000_0000,
        S_LOG    = 11'b001_0000_0000,
        S_LOGW   = 11'b010_0000_0000,
        S_OUT    = 11'b100_0000_0000
    } t_state;

    t_state             r_state, n_state;
    logic [31:0]        r_log_period;
    logic [CLW-1:0]     r_clr;
    logic [SAW-1:0]     r_sec_slot;
    logic [MAW-1:0]     r_min_slot;
    logic [HAW-1:0]     r_hour_slot;
    logic [TIME_W-1:0]  r_t;
    logic               r_filled;
    t_level             r_level;
    logic [PW-1:0]      r_walk_pos;
    logic [PW:0]        r_walk_depth;
    logic [CNT_W-1:0]   r_walk_left;
    logic               r_rd_vld;
    logic signed [SUM_W-1:0] r_sum;
    logic [CNT_W-1:0]   r_cnt;
    logic [TEMP_W-1:0]  r_avg;
    logic               r_log, r_min_done, r_hour_done, r_day_done;
    logic [TEMP_W-1:0]  r_min_avg, r_hour_avg, r_day_avg;
    logic               r_out_valid;
    logic               r_out_log, r_out_min_done, r_out_hour_done, r_out_day_done;
    logic [TEMP_W-1:0]  r_out_min_avg, r_out_hour_avg, r_out_day_avg;

    logic               in_fire, cfg_wr, walk_end;
    logic               div_start;
    logic [DIV_W-1:0]   div_dividend;
    logic [TIME_W-1:0]  div_divisor;
    t_div_status        div_st;
    logic [SUM_W-1:0]   sum_mag;
    logic [ENTRY_W-1:0] rd_sec, rd_min, rd_hour, rd_sel;
    logic               sec_we, min_we, hour_we;
    logic [SAW-1:0]     sec_waddr;
    logic [MAW-1:0]     min_waddr;
    logic [HAW-1:0]     hour_waddr;
    logic [ENTRY_W-1:0] sec_wdata, min_wdata, hour_wdata;
    logic               clearing;
    logic [DIV_W-1:0]   day_t;
    logic [TIME_W-1:0]  mod_opd, mod_inv, mod_lim, mod_prod;
    logic               mod_low_zero, mod_hit;

    // first position of a window of win entries ending just before end_pos
    function automatic logic [PW-1:0] f_start(input logic [PW:0] end_pos,
                                              input logic [PW:0] depth,
                                              input logic [PW:0] win);
        logic [PW+1:0] s;
        s = {1'b0, end_pos} + {1'b0, depth} - {1'b0, win};
        if (s >= {1'b0, depth}) begin
            s = s - {1'b0, depth};
        end
        return s[PW-1:0];
    endfunction

    assign in_fire  = i_in.valid && i_in.ready;
    assign cfg_wr   = psel && penable && pwrite;
    assign walk_end = (r_walk_left == '0) && !r_rd_vld;
    assign clearing = (r_state == S_CLEAR);
    assign sum_mag  = r_sum[SUM_W-1] ? SUM_W'(-r_sum) : SUM_W'(r_sum);

    assign pready   = 1'b1;
    assign prdata   = (paddr[2] == REG_LOG_PERIOD[2]) ? r_log_period : 32'd0;
    assign i_in.ready = (r_state == S_IDLE);

    // ring memories
    always_comb begin
        sec_we     = clearing && ({1'b0, r_clr} < (CLW+1)'(SECOND_DEPTH));
        sec_waddr  = r_clr[SAW-1:0];
        sec_wdata  = '0;
        min_we     = clearing && ({1'b0, r_clr} < (CLW+1)'(MINUTE_DEPTH));
        min_waddr  = r_clr[MAW-1:0];
        min_wdata  = '0;
        hour_we    = clearing && ({1'b0, r_clr} < (CLW+1)'(HOUR_DEPTH));
        hour_waddr = r_clr[HAW-1:0];
        hour_wdata = '0;
        if (r_state == S_IDLE && in_fire) begin
            sec_we    = 1'b1;
            sec_waddr = r_sec_slot;
            sec_wdata = {(i_in.time_seconds != '0), i_in.temperature};
        end
        if (r_state == S_STORE && r_level == LV_SEC) begin
            min_we    = 1'b1;
            min_waddr = r_min_slot;
            min_wdata = {r_filled, r_avg};
        end
        if (r_state == S_STORE && r_level == LV_MIN) begin
            hour_we    = 1'b1;
            hour_waddr = r_hour_slot;
            hour_wdata = {r_filled, r_avg};
        end
    end

    cta_ram #(.WIDTH(ENTRY_W), .DEPTH(SECOND_DEPTH)) u_sec_ram (
        .i_clk(i_clk), .i_we(sec_we), .i_waddr(sec_waddr), .i_wdata(sec_wdata),
        .i_raddr(r_walk_pos[SAW-1:0]), .o_rdata(rd_sec)
    );
    cta_ram #(.WIDTH(ENTRY_W), .DEPTH(MINUTE_DEPTH)) u_min_ram (
        .i_clk(i_clk), .i_we(min_we), .i_waddr(min_waddr), .i_wdata(min_wdata),
        .i_raddr(r_walk_pos[MAW-1:0]), .o_rdata(rd_min)
    );
    cta_ram #(.WIDTH(ENTRY_W), .DEPTH(HOUR_DEPTH)) u_hour_ram (
        .i_clk(i_clk), .i_we(hour_we), .i_waddr(hour_waddr), .i_wdata(hour_wdata),
        .i_raddr(r_walk_pos[HAW-1:0]), .o_rdata(rd_hour)
    );

    always_comb begin
        case (r_level)
            LV_SEC:  rd_sel = rd_sec;
            LV_MIN:  rd_sel = rd_min;
            default: rd_sel = rd_hour;
        endcase
    end

    // minute, hour and day marks (day on time + 3600): low bits zero and the rest a multiple of the odd factor
    always_comb begin
        day_t        = {1'b0, r_t} + DIV_W'(SECS_PER_HOUR);
        mod_opd      = r_t >> MIN_SHIFT;
        mod_inv      = MIN_INV;
        mod_lim      = MIN_LIM;
        mod_low_zero = (r_t[MIN_SHIFT-1:0] == '0);
        if (r_state == S_M3600) begin
            mod_opd      = r_t >> HOUR_SHIFT;
            mod_inv      = HOUR_INV;
            mod_lim      = HOUR_LIM;
            mod_low_zero = (r_t[HOUR_SHIFT-1:0] == '0);
        end else if (r_state == S_M86400) begin
            mod_opd      = TIME_W'(day_t >> DAY_SHIFT);
            mod_inv      = DAY_INV;
            mod_lim      = DAY_LIM;
            mod_low_zero = (day_t[DAY_SHIFT-1:0] == '0);
        end
    end

    assign mod_prod = mod_opd * mod_inv;
    assign mod_hit  = mod_low_zero && (mod_prod <= mod_lim);

    // divider requests
    always_comb begin
        div_start    = 1'b0;
        div_dividend = {1'b0, r_t};
        div_divisor  = r_log_period;
        unique case (r_state) inside
            S_WALK: begin
                div_start    = walk_end && (r_cnt != '0);
                div_dividend = DIV_W'(sum_mag);
                div_divisor  = TIME_W'(r_cnt);
            end
            S_LOG: div_start = (r_log_period != '0);
            S_CLEAR, S_IDLE, S_M60, S_AVG, S_STORE, S_M3600, S_M86400, S_LOGW, S_OUT: ;
            default: ;
        endcase
    end

    cta_div u_div (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(div_start),
        .i_dividend(div_dividend), .i_divisor(div_divisor), .o_status(div_st)
    );

    // sequencer
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_CLEAR:  if (r_clr == CLW'(MAXD - 1)) n_state = S_IDLE;
            S_IDLE:   if (in_fire) n_state = S_M60;
            S_M60:    n_state = mod_hit ? S_WALK : S_LOG;
            S_WALK:   if (walk_end) n_state = (r_cnt == '0) ? S_STORE : S_AVG;
            S_AVG:    if (div_st.done) n_state = S_STORE;
            S_STORE: begin
                case (r_level)
                    LV_SEC:  n_state = S_M3600;
                    LV_MIN:  n_state = S_M86400;
                    default: n_state = S_LOG;
                endcase
            end
            S_M3600:  n_state = mod_hit ? S_WALK : S_LOG;
            S_M86400: n_state = mod_hit ? S_WALK : S_LOG;
            S_LOG:    n_state = (r_log_period != '0) ? S_LOGW : S_OUT;
            S_LOGW:   if (div_st.done) n_state = S_OUT;
            S_OUT:    if (!r_out_valid || o_out.ready) n_state = S_IDLE;
            default:  n_state = S_CLEAR;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= S_CLEAR;
            r_clr          <= '0;
            r_log_period   <= '0;
            r_sec_slot     <= '0;
            r_min_slot     <= '0;
            r_hour_slot    <= '0;
            r_out_valid    <= 1'b0;
            r_rd_vld       <= 1'b0;
            r_walk_left    <= '0;
            r_level        <= LV_SEC;
        end else begin
            r_state <= n_state;
            if (cfg_wr && paddr[2] == REG_LOG_PERIOD[2]) begin
                r_log_period <= pwdata;
            end
            if (r_state == S_OUT && (!r_out_valid || o_out.ready)) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_CLEAR: r_clr <= r_clr + 1'b1;
                S_IDLE: begin
                    if (in_fire) begin
                        r_t         <= i_in.time_seconds;
                        r_filled    <= (i_in.time_seconds != '0);
                        r_log       <= 1'b0;
                        r_min_done  <= 1'b0;
                        r_hour_done <= 1'b0;
                        r_day_done  <= 1'b0;
                        r_min_avg   <= '0;
                        r_hour_avg  <= '0;
                        r_day_avg   <= '0;
                    end
                end
                S_M60: begin
                    r_level      <= LV_SEC;
                    r_walk_pos   <= f_start((PW+1)'(r_sec_slot) + 1'b1,
                                            (PW+1)'(SECOND_DEPTH), (PW+1)'(WIN_SECONDS));
                    r_walk_depth <= (PW+1)'(SECOND_DEPTH);
                    r_walk_left  <= CNT_W'(WIN_SECONDS);
                    r_sum        <= '0;
                    r_cnt        <= '0;
                    r_rd_vld     <= 1'b0;
                end
                S_WALK: begin
                    // address goes out, entry comes back in the next cycle
                    if (r_walk_left != '0) begin
                        r_walk_pos  <= ({1'b0, r_walk_pos} == r_walk_depth - 1'b1)
                                     ? '0 : r_walk_pos + 1'b1;
                        r_walk_left <= r_walk_left - 1'b1;
                        r_rd_vld    <= 1'b1;
                    end else begin
                        r_rd_vld <= 1'b0;
                    end
                    if (r_rd_vld && rd_sel[ENTRY_W-1]) begin
                        r_sum <= r_sum + {{(SUM_W-TEMP_W){rd_sel[TEMP_W-1]}},
                                          rd_sel[TEMP_W-1:0]};
                        r_cnt <= r_cnt + 1'b1;
                    end
                    if (walk_end && r_cnt == '0) begin
                        r_avg <= '0;
                    end
                end
                S_AVG: begin
                    if (div_st.done) begin
                        r_avg <= r_sum[SUM_W-1] ? TEMP_W'(-div_st.quot[TEMP_W-1:0])
                                                : div_st.quot[TEMP_W-1:0];
                    end
                end
                S_STORE: begin
                    case (r_level)
                        LV_SEC: begin
                            r_min_done <= 1'b1;
                            r_min_avg  <= r_avg;
                            r_min_slot <= (r_min_slot == MAW'(MINUTE_DEPTH - 1))
                                        ? '0 : r_min_slot + 1'b1;
                        end
                        LV_MIN: begin
                            r_hour_done <= 1'b1;
                            r_hour_avg  <= r_avg;
                            r_hour_slot <= (r_hour_slot == HAW'(HOUR_DEPTH - 1))
                                         ? '0 : r_hour_slot + 1'b1;
                        end
                        default: begin
                            r_day_done <= 1'b1;
                            r_day_avg  <= r_avg;
                        end
                    endcase
                end
                S_M3600: begin
                    r_level      <= LV_MIN;
                    r_walk_pos   <= f_start((PW+1)'(r_min_slot),
                                            (PW+1)'(MINUTE_DEPTH), (PW+1)'(WIN_MINUTES));
                    r_walk_depth <= (PW+1)'(MINUTE_DEPTH);
                    r_walk_left  <= CNT_W'(WIN_MINUTES);
                    r_sum        <= '0;
                    r_cnt        <= '0;
                    r_rd_vld     <= 1'b0;
                end
                S_M86400: begin
                    r_level      <= LV_HOUR;
                    r_walk_pos   <= f_start((PW+1)'(r_hour_slot),
                                            (PW+1)'(HOUR_DEPTH), (PW+1)'(WIN_HOURS));
                    r_walk_depth <= (PW+1)'(HOUR_DEPTH);
                    r_walk_left  <= CNT_W'(WIN_HOURS);
                    r_sum        <= '0;
                    r_cnt        <= '0;
                    r_rd_vld     <= 1'b0;
                end
                S_LOG: ;
                S_LOGW: begin
                    if (div_st.done) begin
                        r_log <= (div_st.rem == '0);
                    end
                end
                S_OUT: begin
                    if (!r_out_valid || o_out.ready) begin
                        r_out_log       <= r_log;
                        r_out_min_done  <= r_min_done;
                        r_out_min_avg   <= r_min_avg;
                        r_out_hour_done <= r_hour_done;
                        r_out_hour_avg  <= r_hour_avg;
                        r_out_day_done  <= r_day_done;
                        r_out_day_avg   <= r_day_avg;
                        r_sec_slot      <= (r_sec_slot == SAW'(SECOND_DEPTH - 1))
                                         ? '0 : r_sec_slot + 1'b1;
                    end
                end
                default: ;
            endcase
        end
    end

    assign o_out.valid          = r_out_valid;
    assign o_out.log_now        = r_out_log;
    assign o_out.minute_done    = r_out_min_done;
    assign o_out.minute_average = r_out_min_avg;
    assign o_out.hour_done      = r_out_hour_done;
    assign o_out.hour_average   = r_out_hour_avg;
    assign o_out.day_done       = r_out_day_done;
    assign o_out.day_average    = r_out_day_avg;

endmodule

@@ src/cta_checker.sv @@
// ---------------------------------------------------------------------------
// cta_checker
// Port-level checks for the cascaded temperature averager.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module cta_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        i_in_ready,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic        i_min_done,
    input logic [15:0] i_min_avg,
    input logic        i_hour_done,
    input logic [15:0] i_hour_avg,
    input logic        i_day_done
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_min_avg))
        else $error("result item changed while stalled");

    a_hour_needs_minute: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_hour_done |-> i_min_done)
        else $error("hour average without minute average");

    a_day_needs_hour: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_day_done |-> i_hour_done)
        else $error("day average without hour average");

    a_idle_avg_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_min_done |-> i_min_avg == 16'd0 && i_hour_avg == 16'd0)
        else $error("average nonzero without its done flag");

    a_busy_after_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !i_in_ready)
        else $error("item taken while previous item in work");

endmodule

bind cascaded_temperature_averager cta_checker u_cta_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_min_done  (o_out.minute_done),
    .i_min_avg   (o_out.minute_average),
    .i_hour_done (o_out.hour_done),
    .i_hour_avg  (o_out.hour_average),
    .i_day_done  (o_out.day_done)
);

@@ verif/cascaded_temperature_averager_tb.sv @@
`timescale 1ns / 1ps

// ---------------------------------------------------------------------------
// cascaded_temperature_averager_tb
// Drives timestamped temperature samples through the averager and checks
// every result item against a cycle-free predictor of the minute, hour and
// day averaging cascade and of the log interval flag.
// ---------------------------------------------------------------------------
module cascaded_temperature_averager_tb;
    import cta_pkg::*;

    localparam int SEC_D      = 128;
    localparam int MIN_D      = 128;
    localparam int HOUR_D     = 32;
    localparam int N_RANDOM   = 800;
    localparam int SETTLE     = 500;
    localparam int LONG_HOLD  = 3000;
    localparam int CYCLE_CAP  = 3000000;

    typedef struct packed {
        logic               log_now;
        logic               minute_done;
        logic signed [15:0] minute_average;
        logic               hour_done;
        logic signed [15:0] hour_average;
        logic               day_done;
        logic signed [15:0] day_average;
    } t_result;

    typedef struct packed {
        logic               valid;
        logic signed [15:0] value;
    } t_entry;

    class averager_scoreboard;
        t_entry         sec_ring[SEC_D];
        t_entry         min_ring[MIN_D];
        t_entry         hour_ring[HOUR_D];
        int unsigned    sec_pos;
        int unsigned    min_pos;
        int unsigned    hour_pos;
        logic [31:0]    log_period;
        t_result        expected_q[$];
        int             errors;

        function void clear();
            for (int i = 0; i < SEC_D; i++) sec_ring[i] = '0;
            for (int i = 0; i < MIN_D; i++) min_ring[i] = '0;
            for (int i = 0; i < HOUR_D; i++) hour_ring[i] = '0;
            sec_pos = 0;
            min_pos = 0;
            hour_pos = 0;
            log_period = '0;
            errors = 0;
        endfunction

        // mean of the filled entries among the count slots just before stop
        function logic signed [15:0] ring_mean(ref t_entry ring[], input int depth,
                                               input int stop, input int count);
            int sum;
            int filled;
            int p;
            sum = 0;
            filled = 0;
            p = (stop + 2 * depth - count) % depth;
            for (int i = 0; i < count; i++) begin
                if (ring[p].valid) begin
                    sum += int'(ring[p].value);
                    filled++;
                end
                p = (p + 1) % depth;
            end
            return (filled == 0) ? 16'sd0 : 16'(sum / filled);
        endfunction

        function void note_sample(logic signed [15:0] temp, logic [31:0] ts);
            t_result r;
            t_entry  tmp[];
            logic    filled;
            int      last_min;
            r = '0;
            filled = (ts != 0);
            sec_ring[sec_pos] = {filled, temp};
            if (ts % SECS_PER_MIN == 0) begin
                tmp = new[SEC_D];
                foreach (tmp[i]) tmp[i] = sec_ring[i];
                r.minute_done = 1'b1;
                r.minute_average = ring_mean(tmp, SEC_D, sec_pos + 1, WIN_SECONDS);
                min_ring[min_pos] = {filled, r.minute_average};
                min_pos = (min_pos + 1) % MIN_D;
                if (ts % SECS_PER_HOUR == 0) begin
                    tmp = new[MIN_D];
                    foreach (tmp[i]) tmp[i] = min_ring[i];
                    last_min = (min_pos + MIN_D - 1) % MIN_D;
                    r.hour_done = 1'b1;
                    r.hour_average = ring_mean(tmp, MIN_D, min_pos, WIN_MINUTES);
                    hour_ring[hour_pos] = {min_ring[last_min].valid, r.hour_average};
                    hour_pos = (hour_pos + 1) % HOUR_D;
                    if ((33'(ts) + 33'(SECS_PER_HOUR)) % SECS_PER_DAY == 0) begin
                        tmp = new[HOUR_D];
                        foreach (tmp[i]) tmp[i] = hour_ring[i];
                        r.day_done = 1'b1;
                        r.day_average = ring_mean(tmp, HOUR_D, hour_pos, WIN_HOURS);
                    end
                end
            end
            r.log_now = (log_period != 0) && (ts % log_period == 0);
            sec_pos = (sec_pos + 1) % SEC_D;
            expected_q.push_back(r);
        endfunction

        function void check_result(t_result got);
            t_result want;
            if (expected_q.size() == 0) begin
                $display("%0t: unexpected result item %h", $time, got);
                errors++;
                return;
            end
            want = expected_q.pop_front();
            if (got.log_now !== want.log_now) begin
                $display("%0t: log_now exp %0d got %0d", $time, want.log_now, got.log_now);
                errors++;
            end
            if (got.minute_done !== want.minute_done ||
                got.minute_average !== want.minute_average) begin
                $display("%0t: minute exp %0d/%0d got %0d/%0d", $time, want.minute_done,
                         want.minute_average, got.minute_done, got.minute_average);
                errors++;
            end
            if (got.hour_done !== want.hour_done ||
                got.hour_average !== want.hour_average) begin
                $display("%0t: hour exp %0d/%0d got %0d/%0d", $time, want.hour_done,
                         want.hour_average, got.hour_done, got.hour_average);
                errors++;
            end
            if (got.day_done !== want.day_done ||
                got.day_average !== want.day_average) begin
                $display("%0t: day exp %0d/%0d got %0d/%0d", $time, want.day_done,
                         want.day_average, got.day_done, got.day_average);
                errors++;
            end
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    cta_in_if  smp();
    cta_out_if res();

    cascaded_temperature_averager dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (smp.sink),
        .o_out   (res.source),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    averager_scoreboard sb;
    bit          idling_on;
    bit          hold_request;
    int unsigned cycle_count;
    int          sent;

    always begin
        i_clk = 1'b0;
        #4;
        i_clk = 1'b1;
        #4;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_CAP) begin
            $display("[cascaded_temperature_averager] ERROR");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && smp.valid && smp.ready)
            sb.note_sample(smp.temperature, smp.time_seconds);
        if (i_rst_n && res.valid && res.ready)
            sb.check_result({res.log_now, res.minute_done, res.minute_average,
                             res.hour_done, res.hour_average, res.day_done,
                             res.day_average});
    end

    // result side: random stalls, plus a long hold-off on each request
    initial begin
        int burst;
        res.ready = 1'b0;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (hold_request) begin
                res.ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge i_clk);
                hold_request = 1'b0;
            end else if (idling_on && $urandom_range(0, 3) == 0) begin
                burst = $urandom_range(1, 15);
                res.ready <= 1'b0;
                repeat (burst) @(posedge i_clk);
            end else begin
                res.ready <= 1'b1;
                @(posedge i_clk);
            end
        end
    end

    // offers one item and returns at the edge that takes it, valid still high
    task automatic send_sample(logic signed [15:0] temp, logic [31:0] ts);
        int burst;
        if (idling_on && $urandom_range(0, 4) == 0) begin
            burst = $urandom_range(1, 15);
            smp.valid <= 1'b0;
            repeat (burst) @(posedge i_clk);
        end
        smp.valid        <= 1'b1;
        smp.temperature  <= temp;
        smp.time_seconds <= ts;
        do @(posedge i_clk); while (!smp.ready);
        sent++;
    endtask

    task automatic drain();
        smp.valid <= 1'b0;
        @(posedge i_clk);
        while (sb.expected_q.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_log_period(logic [31:0] value);
        drain();
        // extra settling time; the block is already idle once its last result is taken
        repeat (SETTLE) @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= REG_LOG_PERIOD;
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        sb.log_period = value;
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    function automatic logic signed [15:0] rand_temp();
        case ($urandom_range(0, 5))
            0: return 16'sh8000;
            1: return 16'sh7fff;
            2: return 16'(int'($urandom_range(0, 12800)) - 2560);
            default: return 16'($urandom);
        endcase
    endfunction

    // one well-formed run or a bit of noise
    task automatic random_sequence();
        int          n;
        logic [31:0] stop;
        case ($urandom_range(0, 9))
            0, 1, 2, 3: begin
                n = $urandom_range(1, 70);
                stop = 60 * $urandom_range(2, 71582787);
                for (int i = n - 1; i >= 0; i--) send_sample(rand_temp(), stop - i);
            end
            4, 5: begin
                n = $urandom_range(1, 65);
                stop = 3600 * $urandom_range(1, 1193045);
                for (int i = n - 1; i >= 0; i--) begin
                    if ($urandom_range(0, 3) == 0) send_sample(rand_temp(), stop - 60 * i - 1);
                    send_sample(rand_temp(), stop - 60 * i);
                end
            end
            6: begin
                n = $urandom_range(1, 30);
                stop = 86400 * $urandom_range(1, 49710) - 3600;
                for (int i = n - 1; i >= 0; i--) send_sample(rand_temp(), stop - 3600 * i);
            end
            7: send_sample(rand_temp(), ($urandom_range(0, 7) == 0) ? 32'd0 : $urandom);
            default: begin
                n = $urandom_range(1, 8);
                stop = $urandom;
                for (int i = 0; i < n; i++) send_sample(rand_temp(), stop + i);
            end
        endcase
    endtask

    initial begin
        logic [31:0] intervals [6];
        sb = new();
        sb.clear();
        idling_on    = 1'b1;
        hold_request = 1'b0;
        cycle_count  = 0;
        sent         = 0;
        i_rst_n = 1'b0;
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
        paddr   = '0;
        pwdata  = '0;
        smp.valid        = 1'b0;
        smp.temperature  = '0;
        smp.time_seconds = '0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: zero timestamp, field extremes, minute, hour and day marks
        write_log_period(32'd60);
        send_sample(16'sh7fff, 32'd0);
        send_sample(16'sh8000, 32'd1);
        send_sample(16'sh7fff, 32'd59);
        send_sample(16'sh8000, 32'd60);
        send_sample(16'sh7fff, 32'd61);
        send_sample(16'sh0000, 32'd120);
        send_sample(16'sh8000, 32'd3599);
        send_sample(16'sh7fff, 32'd3600);
        send_sample(16'shffff, 32'd82800);
        send_sample(16'sh0100, 32'd169200);
        send_sample(16'sh8000, 32'd4294940400);
        send_sample(16'sh7fff, 32'hffffffff);
        send_sample(16'sh5555, 32'h55555555);
        send_sample(16'shaaaa, 32'haaaaaaaa);
        send_sample(16'sh0001, 32'd0);
        for (int i = 0; i < 8; i++) send_sample(16'(16'sh8000 + i), 32'd7140 + 60 * i);

        intervals[0] = 32'd1;
        intervals[1] = 32'hffffffff;
        intervals[2] = 32'd7;
        intervals[3] = $urandom;
        intervals[4] = 32'd3600;
        intervals[5] = 32'd0;
        sent = 0;
        for (int ph = 0; ph < 6; ph++) begin
            write_log_period(intervals[ph]);
            while (sent < (ph + 1) * N_RANDOM / 6) begin
                if (ph == 1 && sent > N_RANDOM / 5 && !hold_request && sent < N_RANDOM / 4)
                    hold_request = 1'b1;
                if (ph == 2 && $urandom_range(0, 40) == 0) drain();
                if (ph == 5 && sent > N_RANDOM * 9 / 10) idling_on = 1'b0;
                random_sequence();
            end
        end

        drain();
        repeat (SETTLE) @(posedge i_clk);
        if (sb.errors == 0 && sb.expected_q.size() == 0) begin
            $display("[cascaded_temperature_averager] OK");
        end else begin
            $display("[cascaded_temperature_averager] ERROR");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
src/cta_pkg.sv
src/cta_if.sv
src/cta_ram.sv
src/cta_div.sv
src/cascaded_temperature_averager.sv
src/cta_checker.sv
verif/cascaded_temperature_averager_tb.sv
